@@ src/fraction_sum_quotient_unit_assert.svh @@
// Assertion macros shared by the RTL.
`ifndef FRACTION_SUM_QUOTIENT_UNIT_ASSERT_SVH
`define FRACTION_SUM_QUOTIENT_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FSQU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) ((ante) |-> (cons))) \
		else $error("assertion failed");

// Next-cycle implication.
`define FSQU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) ((ante) |=> (cons))) \
		else $error("assertion failed");

`endif

@@ src/fsqu_pkg.sv @@
`default_nettype none
package fsqu_pkg;
	localparam int OPERAND_BITS = 32;
	localparam int FIELD_W = 32;
	localparam int IN_W = 4 * FIELD_W;
	localparam int WIDE_W = 64;
	localparam int NARROW_W = 63;
	localparam int OUT_FIELDS_W = 6 * NARROW_W + WIDE_W;
	localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int DIV_W = 64;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_DEN_ZERO = 2'd1;
	localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_ZERO_ALL,
		OP_GCD_DEN,
		OP_DIV_GCD,
		OP_DIV_FA,
		OP_DIV_FB,
		OP_MUL_LCM,
		OP_MUL_CA,
		OP_MUL_CB,
		OP_SUM_INIT,
		OP_DIV_SN,
		OP_DIV_SD,
		OP_MUL_QN,
		OP_MUL_QD,
		OP_QUO_INIT,
		OP_ZERO_QUOT,
		OP_DIV_QN,
		OP_DIV_QD,
		OP_PUBLISH
	} op_t;

	typedef struct packed {
		logic den_zero;
		logic x_zero;
		logic y_zero;
		logic div_done;
	} dp_sts_t;
endpackage
`default_nettype wire

@@ src/fraction_sum_quotient_unit.sv @@
// Fraction sum and quotient unit.
// Input stream: one request per pair of fractions a = a_num/a_den, b = b_num/b_den,
// taken when s_tvalid and s_tready are high at a rising edge.
// Output stream: one result per request, held in an output register until
// m_tvalid and m_tready are both high. m_tuser carries the status code.
// One request is worked at a time; s_tready is high only while the controller
// waits for work, so a finished result may still wait at the output while the
// next request is taken.
// Each division is issued to the shared 64-bit radix-2 divider and waited for.
// Three gcd runs (one division per Euclid step) and up to six quotient divisions
// run on it, so the time a request takes depends on operand values; a zero
// denominator skips every division.
// Reset clears the controller and drops any result not yet taken.
// A stalled output blocks only the final publish step.
`default_nettype none
`include "fraction_sum_quotient_unit_assert.svh"
module fraction_sum_quotient_unit import fsqu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// common_a_num[62:0], common_b_num[125:63], common_den[188:126],
	// sum_num[252:189], sum_den[315:253], quot_num[378:316], quot_den[441:379]
	output logic [OUT_W-1:0]      m_tdata,
	// status[1:0]
	output logic [1:0]            m_tuser
);
	op_t op;
	dp_sts_t sts;

	fsqu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.op       (op),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid)
	);

	fsqu_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.op      (op),
		.sts     (sts),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	`FSQU_ASSERT_NXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`FSQU_ASSERT_IMP(a_status_code, clk, arst_n, m_tvalid, m_tuser <= STATUS_DIV_ZERO)
	`FSQU_ASSERT_IMP(a_den_zero_clear, clk, arst_n,
		m_tvalid && m_tuser == STATUS_DEN_ZERO, m_tdata == '0)
endmodule
`default_nettype wire

@@ src/fsqu_div.sv @@
`default_nettype none
module fsqu_div import fsqu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_W-1:0]  dividend,
	input  wire logic [DIV_W-1:0]  divisor,
	output logic                   done,
	output logic [DIV_W-1:0]       quo,
	output logic [DIV_W-1:0]       rem
);
	logic [DIV_W-1:0] rem_q, quo_q, dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DIV_W:0] trial, diff;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ~diff[DIV_W]};
		end
	end

	assign done = done_q;
	assign quo = quo_q;
	assign rem = rem_q;
endmodule
`default_nettype wire

@@ src/fsqu_dp.sv @@
`default_nettype none
module fsqu_dp import fsqu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire op_t              op,
	output dp_sts_t               sts,
	output logic [OUT_W-1:0]      m_tdata,
	output logic [1:0]            m_tuser
);
	logic [FIELD_W-1:0] an_q, ad_q, bn_q, bd_q, fa_q, fb_q;
	logic [WIDE_W-1:0] x_q, y_q, smag_q, lmag_q, lcm_q, ca_q, cb_q, qn_q, qd_q;
	logic [WIDE_W-1:0] sum_num_q, sum_den_q, qnum_q, qden_q;
	logic [1:0] status_q;
	op_t div_op_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic [1:0] m_tuser_q;

	logic div_start, div_done;
	logic [DIV_W-1:0] div_a, div_b, div_quo, div_rem;
	logic [FIELD_W-1:0] mul_a, mul_b;
	logic mul_neg;
	logic [WIDE_W-1:0] prod, mul_val, sum_s;
	logic [FIELD_W-1:0] in_an, in_ad, in_bn, in_bd;

	function automatic logic [FIELD_W-1:0] mag32(input logic [FIELD_W-1:0] v);
		return v[FIELD_W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [WIDE_W-1:0] mag64(input logic [WIDE_W-1:0] v);
		return v[WIDE_W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [WIDE_W-1:0] sgn64(input logic [WIDE_W-1:0] v, input logic n);
		return n ? (~v + 1'b1) : v;
	endfunction

	assign in_an = FIELD_W'(signed'(s_tdata[OPERAND_BITS-1:0]));
	assign in_ad = FIELD_W'(signed'(s_tdata[FIELD_W+OPERAND_BITS-1:FIELD_W]));
	assign in_bn = FIELD_W'(signed'(s_tdata[2*FIELD_W+OPERAND_BITS-1:2*FIELD_W]));
	assign in_bd = FIELD_W'(signed'(s_tdata[3*FIELD_W+OPERAND_BITS-1:3*FIELD_W]));

	always_comb begin
		div_start = 1'b1;
		div_a = x_q;
		div_b = y_q;
		unique case (op)
			OP_DIV_GCD: div_a = x_q;
			OP_DIV_FA: begin
				div_a = WIDE_W'(mag32(bd_q));
				div_b = x_q;
			end
			OP_DIV_FB: begin
				div_a = WIDE_W'(mag32(ad_q));
				div_b = x_q;
			end
			OP_DIV_SN: begin
				div_a = smag_q;
				div_b = x_q;
			end
			OP_DIV_SD: begin
				div_a = lmag_q;
				div_b = x_q;
			end
			OP_DIV_QN: begin
				div_a = mag64(qn_q);
				div_b = x_q;
			end
			OP_DIV_QD: begin
				div_a = mag64(qd_q);
				div_b = x_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	always_comb begin
		mul_a = mag32(an_q);
		mul_b = fa_q;
		mul_neg = an_q[FIELD_W-1] ^ bd_q[FIELD_W-1];
		unique case (op)
			OP_MUL_LCM: begin
				mul_a = mag32(ad_q);
				mul_neg = ad_q[FIELD_W-1] ^ bd_q[FIELD_W-1];
			end
			OP_MUL_CB: begin
				mul_a = mag32(bn_q);
				mul_b = fb_q;
				mul_neg = bn_q[FIELD_W-1] ^ ad_q[FIELD_W-1];
			end
			OP_MUL_QN: mul_b = mag32(bd_q);
			OP_MUL_QD: begin
				mul_a = mag32(ad_q);
				mul_b = mag32(bn_q);
				mul_neg = ad_q[FIELD_W-1] ^ bn_q[FIELD_W-1];
			end
			default: mul_b = fa_q;
		endcase
	end

	assign prod = WIDE_W'(mul_a) * WIDE_W'(mul_b);
	assign mul_val = sgn64(prod, mul_neg);
	assign sum_s = ca_q + cb_q;

	fsqu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk) begin
		if (div_start)
			div_op_q <= op;
		if (div_done) begin
			unique case (div_op_q)
				OP_DIV_GCD: begin
					x_q <= y_q;
					y_q <= div_rem;
				end
				OP_DIV_FA: fa_q <= div_quo[FIELD_W-1:0];
				OP_DIV_FB: fb_q <= div_quo[FIELD_W-1:0];
				OP_DIV_SN: sum_num_q <= sgn64(div_quo, smag_q != '0 && sum_s[WIDE_W-1]);
				OP_DIV_SD: sum_den_q <= sgn64(div_quo, lcm_q[WIDE_W-1]);
				OP_DIV_QN: qnum_q <= sgn64(div_quo, qn_q[WIDE_W-1]);
				OP_DIV_QD: qden_q <= sgn64(div_quo, qd_q[WIDE_W-1]);
				default: ;
			endcase
		end
		unique case (op)
			OP_LOAD: begin
				an_q <= in_an;
				ad_q <= in_ad;
				bn_q <= in_bn;
				bd_q <= in_bd;
				if (in_ad == '0 || in_bd == '0)
					status_q <= STATUS_DEN_ZERO;
				else if (in_bn == '0)
					status_q <= STATUS_DIV_ZERO;
				else
					status_q <= STATUS_OK;
			end
			OP_ZERO_ALL: begin
				ca_q <= '0;
				cb_q <= '0;
				lcm_q <= '0;
				sum_num_q <= '0;
				sum_den_q <= '0;
				qnum_q <= '0;
				qden_q <= '0;
			end
			OP_GCD_DEN: begin
				x_q <= WIDE_W'(mag32(ad_q));
				y_q <= WIDE_W'(mag32(bd_q));
			end
			OP_MUL_LCM: lcm_q <= mul_val;
			OP_MUL_CA: ca_q <= mul_val;
			OP_MUL_CB: cb_q <= mul_val;
			OP_SUM_INIT: begin
				x_q <= mag64(sum_s);
				smag_q <= mag64(sum_s);
				y_q <= mag64(lcm_q);
				lmag_q <= mag64(lcm_q);
			end
			OP_MUL_QN: qn_q <= mul_val;
			OP_MUL_QD: qd_q <= mul_val;
			OP_QUO_INIT: begin
				x_q <= mag64(qn_q);
				y_q <= mag64(qd_q);
			end
			OP_ZERO_QUOT: begin
				qnum_q <= '0;
				qden_q <= '0;
			end
			OP_PUBLISH: begin
				m_tdata_q <= {(OUT_W - OUT_FIELDS_W)'(0), qden_q[NARROW_W-1:0],
					qnum_q[NARROW_W-1:0], sum_den_q[NARROW_W-1:0], sum_num_q,
					lcm_q[NARROW_W-1:0], cb_q[NARROW_W-1:0], ca_q[NARROW_W-1:0]};
				m_tuser_q <= status_q;
			end
			default: ;
		endcase
	end

	assign sts.den_zero = (ad_q == '0) || (bd_q == '0);
	assign sts.x_zero = (x_q == '0);
	assign sts.y_zero = (y_q == '0);
	assign sts.div_done = div_done;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
endmodule
`default_nettype wire

@@ src/fsqu_ctrl.sv @@
`default_nettype none
module fsqu_ctrl import fsqu_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	input  wire logic    m_tready,
	input  wire dp_sts_t sts,
	output op_t          op,
	output logic         s_tready,
	output logic         m_tvalid
);
	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_CHECK = 18'h00002,
		S_GCD   = 18'h00004,
		S_DIVW  = 18'h00008,
		S_FA    = 18'h00010,
		S_FB    = 18'h00020,
		S_MLCM  = 18'h00040,
		S_MCA   = 18'h00080,
		S_MCB   = 18'h00100,
		S_SUMI  = 18'h00200,
		S_SN    = 18'h00400,
		S_SD    = 18'h00800,
		S_MQN   = 18'h01000,
		S_MQD   = 18'h02000,
		S_QUOI  = 18'h04000,
		S_QN    = 18'h08000,
		S_QD    = 18'h10000,
		S_PUB   = 18'h20000
	} state_t;

	state_t state_q, state_d, gret_q, gret_d, dret_q, dret_d;
	logic out_valid_q, out_valid_d;

	always_comb begin
		state_d = state_q;
		gret_d = gret_q;
		dret_d = dret_q;
		out_valid_d = out_valid_q && !m_tready;
		op = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					op = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.den_zero) begin
					op = OP_ZERO_ALL;
					state_d = S_PUB;
				end else begin
					op = OP_GCD_DEN;
					gret_d = S_FA;
					state_d = S_GCD;
				end
			end
			S_GCD: begin
				if (sts.y_zero) begin
					state_d = gret_q;
				end else begin
					op = OP_DIV_GCD;
					dret_d = S_GCD;
					state_d = S_DIVW;
				end
			end
			S_DIVW: begin
				if (sts.div_done)
					state_d = dret_q;
			end
			S_FA: begin
				op = OP_DIV_FA;
				dret_d = S_FB;
				state_d = S_DIVW;
			end
			S_FB: begin
				op = OP_DIV_FB;
				dret_d = S_MLCM;
				state_d = S_DIVW;
			end
			S_MLCM: begin
				op = OP_MUL_LCM;
				state_d = S_MCA;
			end
			S_MCA: begin
				op = OP_MUL_CA;
				state_d = S_MCB;
			end
			S_MCB: begin
				op = OP_MUL_CB;
				state_d = S_SUMI;
			end
			S_SUMI: begin
				op = OP_SUM_INIT;
				gret_d = S_SN;
				state_d = S_GCD;
			end
			S_SN: begin
				op = OP_DIV_SN;
				dret_d = S_SD;
				state_d = S_DIVW;
			end
			S_SD: begin
				op = OP_DIV_SD;
				dret_d = S_MQN;
				state_d = S_DIVW;
			end
			S_MQN: begin
				op = OP_MUL_QN;
				state_d = S_MQD;
			end
			S_MQD: begin
				op = OP_MUL_QD;
				state_d = S_QUOI;
			end
			S_QUOI: begin
				op = OP_QUO_INIT;
				gret_d = S_QN;
				state_d = S_GCD;
			end
			S_QN: begin
				if (sts.x_zero) begin
					op = OP_ZERO_QUOT;
					state_d = S_PUB;
				end else begin
					op = OP_DIV_QN;
					dret_d = S_QD;
					state_d = S_DIVW;
				end
			end
			S_QD: begin
				op = OP_DIV_QD;
				dret_d = S_PUB;
				state_d = S_DIVW;
			end
			S_PUB: begin
				if (!out_valid_q || m_tready) begin
					op = OP_PUBLISH;
					out_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gret_q <= S_IDLE;
			dret_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			gret_q <= gret_d;
			dret_q <= dret_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
endmodule
`default_nettype wire
